// ===== rtl/core/glw_pkg.sv =====
// Shared types, constants and offset arithmetic for the glyph line wrap layout block.
`default_nettype none
package glw_pkg;

  localparam int MAX_GLYPHS_DEF = 64;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int CNT_W          = 7;   // glyph and line counts, up to 64
  localparam int ROW_W          = 6;   // line index field
  localparam int POS_W          = 19;  // quarter-pixel positions and pen registers
  localparam int HGT_W          = 9;   // line heights
  localparam int ACC_W          = 24;  // working width of the position arithmetic
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 12;

  localparam logic signed [ACC_W-1:0] POS_HI = ACC_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] POS_LO = ACC_W'(-(2 ** (POS_W - 1)));

  // Register indexes of the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_HALF_HEIGHT = 3'd1,
    REG_GAP_X       = 3'd2,
    REG_GAP_Y       = 3'd3,
    REG_SINGLE_LINE = 3'd4,
    REG_ALIGN_H     = 3'd5,
    REG_ALIGN_V     = 3'd6
  } reg_idx_t;

  // Alignment codes
  localparam logic [1:0] ALIGN_FIRST  = 2'd0;  // left / top
  localparam logic [1:0] ALIGN_MIDDLE = 2'd1;  // centre / middle
  localparam logic [1:0] ALIGN_LAST   = 2'd2;  // right / bottom

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_CLIP_RD,
    ST_CLIP_ROW,
    ST_CLIP_CHK,
    ST_SCAN,
    ST_HF_RD,
    ST_HL_RD,
    ST_OFFS,
    ST_EMIT_RD,
    ST_EMIT_ROW,
    ST_EMIT_CALC,
    ST_EMIT_OUT
  } state_t;

  typedef enum logic [1:0] {
    RSEL_GLYPH,
    RSEL_FIRST,
    RSEL_LAST
  } row_sel_t;

  typedef struct packed {
    logic     load;        // input beat taken this cycle
    logic     row_track;   // keep the line store in step with the current line
    logic     flush;       // end of input: first vertical offset
    logic     clip_chk;
    logic     scan_step;
    logic     cap_hf;
    logic     set_oy;      // final vertical offset
    logic     emit_calc;
    logic     idx_clr;
    logic     idx_inc;
    logic     end_run;
    row_sel_t row_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic idx_last_glyph;
    logic idx_last_row;
  } status_t;

  typedef struct packed {
    logic                    brk;
    logic [ROW_W-1:0]        row;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } glyph_rec_t;

  typedef struct packed {
    logic signed [POS_W-1:0] w;
    logic [HGT_W-1:0]        h;
  } row_rec_t;

  function automatic logic signed [ACC_W-1:0] v_offset(
      input logic [1:0]              av,
      input logic signed [ACC_W-1:0] hh,
      input logic signed [ACC_W-1:0] tot,
      input logic signed [ACC_W-1:0] hf,
      input logic signed [ACC_W-1:0] hl);
    logic signed [ACC_W-1:0] span;
    logic signed [ACC_W-1:0] res;
    span = (hh <<< 1) - tot;
    case (av)
      ALIGN_FIRST:  res = -(hf <<< 2);
      ALIGN_MIDDLE: res = -(span <<< 1) - (hf <<< 1);
      ALIGN_LAST:   res = -(span <<< 2) + (hl <<< 1);
      default:      res = '0;
    endcase
    return res;
  endfunction

  function automatic logic signed [ACC_W-1:0] h_offset(
      input logic [1:0]              ah,
      input logic signed [ACC_W-1:0] hw,
      input logic signed [ACC_W-1:0] w);
    logic signed [ACC_W-1:0] span;
    logic signed [ACC_W-1:0] res;
    span = (hw <<< 1) - w;
    case (ah)
      ALIGN_MIDDLE: res = span <<< 1;
      ALIGN_LAST:   res = span <<< 2;
      default:      res = '0;
    endcase
    return res;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > POS_HI) c = POS_HI;
    if (v < POS_LO) c = POS_LO;
    return c[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/glw_glyph_if.sv =====
// Glyph metrics channel: valid, ready and one glyph's fields.
`default_nettype none
interface glw_glyph_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] bearing_left;
  logic signed [8:0] bearing_top;
  logic [7:0]        advance;
  logic [7:0]        box_width;
  logic [7:0]        box_height;
  logic              is_newline;
  logic              final_glyph;

  modport source (output valid, bearing_left, bearing_top, advance, box_width, box_height,
                  is_newline, final_glyph, input ready);
  modport sink (input valid, bearing_left, bearing_top, advance, box_width, box_height,
                is_newline, final_glyph, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/glw_result_if.sv =====
// Placed glyph channel: valid, ready and one result's fields.
`default_nettype none
interface glw_result_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] pos_x;
  logic signed [18:0] pos_y;
  logic [5:0]         row;
  logic               visible;
  logic               dropped;
  logic               last_out;

  modport source (output valid, pos_x, pos_y, row, visible, dropped, last_out, input ready);
  modport sink (input valid, pos_x, pos_y, row, visible, dropped, last_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/glyph_line_wrap_layout.sv =====
// Glyph line wrap layout: top level joining sequencer and datapath.
// Usage:
//   glyphs  - one glyph's metrics per beat; a beat with final_glyph closes the text.
//   results - one beat per stored glyph, in input order, after the final glyph;
//             last_out marks the last beat. A text with no stored glyph gives one
//             beat with zero position and row, visible low and last_out set.
//   write_en/write_index/write_data - settings writes; the user writes only while
//             idle, which the block itself does not enforce.
// Throughput: glyph beats are taken one per cycle while input is open. After the
// final beat the block runs a flush step, a clipping pass (store read, line read
// and check per glyph), a line search through the lines, the final offset (first
// line read, last line read, offset), then each result (store read, line read,
// compute, hand over while the receiver is ready). Input is not taken again until
// the last result beat has gone. Reset restores the default settings and returns
// to taking glyphs; the glyph and line stores are not cleared. A stalled receiver
// holds the result beat steady until it is taken.
`default_nettype none
module glyph_line_wrap_layout
  import glw_pkg::*;
#(
  parameter int MAX_GLYPHS = MAX_GLYPHS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  glw_glyph_if.sink                  glyphs,
  glw_result_if.source               results,
  input  wire logic                  write_en,
  input  wire logic [CFG_IDX_W-1:0]  write_index,
  input  wire logic [CFG_DATA_W-1:0] write_data
);

  cmd_t    cmd;
  status_t status;

  glw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (glyphs.valid),
    .in_final  (glyphs.final_glyph),
    .in_ready  (glyphs.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  glw_datapath #(
    .MAX_GLYPHS (MAX_GLYPHS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .write_en     (write_en),
    .write_index  (write_index),
    .write_data   (write_data),
    .bearing_left (glyphs.bearing_left),
    .bearing_top  (glyphs.bearing_top),
    .advance      (glyphs.advance),
    .box_width    (glyphs.box_width),
    .box_height   (glyphs.box_height),
    .is_newline   (glyphs.is_newline),
    .cmd          (cmd),
    .status       (status),
    .pos_x        (results.pos_x),
    .pos_y        (results.pos_y),
    .row          (results.row),
    .visible      (results.visible),
    .dropped      (results.dropped),
    .last_out     (results.last_out)
  );

  // Input and output sides never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(glyphs.ready && results.valid)) else $error("input taken while a result is offered");

  // The final beat stops input intake
  a_final_stops: assert property (@(posedge clk) disable iff (rst)
    (glyphs.valid && glyphs.ready && glyphs.final_glyph) |=> !glyphs.ready)
    else $error("input still open after final beat");

  // The last result beat reopens input
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.last_out) |=> glyphs.ready)
    else $error("input not reopened after last result");

endmodule
`default_nettype wire

// ===== rtl/core/glw_ctrl.sv =====
// Sequencer: load, clip, scan, offset and emit phases of a layout run.
`default_nettype none
module glw_ctrl
  import glw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_final,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.row_sel = RSEL_GLYPH;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready      = 1'b1;
        cmd.row_track = 1'b1;
        cmd.load      = in_valid;
        if (in_valid && in_final) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.row_track = 1'b1;
        cmd.flush     = 1'b1;
        cmd.idx_clr   = 1'b1;
        state_next    = status.empty ? ST_EMIT_CALC : ST_CLIP_RD;
      end
      ST_CLIP_RD:  state_next = ST_CLIP_ROW;
      ST_CLIP_ROW: state_next = ST_CLIP_CHK;
      ST_CLIP_CHK: begin
        cmd.clip_chk = 1'b1;
        if (status.idx_last_glyph) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_SCAN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_CLIP_RD;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.idx_last_row) state_next = ST_HF_RD;
        else cmd.idx_inc = 1'b1;
      end
      ST_HF_RD: begin
        cmd.row_sel = RSEL_FIRST;
        state_next  = ST_HL_RD;
      end
      ST_HL_RD: begin
        cmd.row_sel = RSEL_LAST;
        cmd.cap_hf  = 1'b1;
        state_next  = ST_OFFS;
      end
      ST_OFFS: begin
        cmd.set_oy  = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = ST_EMIT_RD;
      end
      ST_EMIT_RD:  state_next = ST_EMIT_ROW;
      ST_EMIT_ROW: state_next = ST_EMIT_CALC;
      ST_EMIT_CALC: begin
        cmd.emit_calc = 1'b1;
        state_next    = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.empty || status.idx_last_glyph) begin
            cmd.end_run = 1'b1;
            state_next  = ST_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/glw_datapath.sv =====
// Layout datapath: settings, pen and line state, glyph and line stores, offsets, result register.
`default_nettype none
module glw_datapath
  import glw_pkg::*;
#(
  parameter int MAX_GLYPHS = MAX_GLYPHS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    write_en,
  input  wire logic [CFG_IDX_W-1:0]    write_index,
  input  wire logic [CFG_DATA_W-1:0]   write_data,
  input  wire logic signed [7:0]       bearing_left,
  input  wire logic signed [8:0]       bearing_top,
  input  wire logic [7:0]              advance,
  input  wire logic [7:0]              box_width,
  input  wire logic [7:0]              box_height,
  input  wire logic                    is_newline,
  input  wire cmd_t                    cmd,
  output status_t                      status,
  output logic signed [POS_W-1:0]      pos_x,
  output logic signed [POS_W-1:0]      pos_y,
  output logic [ROW_W-1:0]             row,
  output logic                         visible,
  output logic                         dropped,
  output logic                         last_out
);

  localparam int GA_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Settings
  logic [11:0]       half_width, half_height;
  logic signed [7:0] gap_x, gap_y;
  logic              single_line;
  logic [1:0]        align_h, align_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= 12'd256;
      half_height <= 12'd64;
      gap_x       <= '0;
      gap_y       <= '0;
      single_line <= 1'b0;
      align_h     <= ALIGN_FIRST;
      align_v     <= ALIGN_FIRST;
    end else if (write_en) begin
      case (write_index)
        REG_HALF_WIDTH:  half_width  <= write_data;
        REG_HALF_HEIGHT: half_height <= write_data;
        REG_GAP_X:       gap_x       <= write_data[7:0];
        REG_GAP_Y:       gap_y       <= write_data[7:0];
        REG_SINGLE_LINE: single_line <= write_data[0];
        REG_ALIGN_H:     align_h     <= write_data[1:0];
        REG_ALIGN_V:     align_v     <= write_data[1:0];
        default: ;
      endcase
    end
  end

  // Run state
  logic                    in_run, overflow;
  logic signed [POS_W-1:0] pen_x, pen_y, total_h, cur_w;
  logic [HGT_W-1:0]        prev_h, cur_h, h_first;
  logic [CNT_W-1:0]        g_cnt, r_cnt;

  // Current state, or a fresh run when none is open
  logic                    e_ovf;
  logic signed [POS_W-1:0] e_px, e_py, e_tot, e_w;
  logic [HGT_W-1:0]        e_prev, e_h, e_hf;
  logic [CNT_W-1:0]        e_g, e_rc;

  always_comb begin
    if (in_run) begin
      e_ovf = overflow; e_px = pen_x; e_py = pen_y; e_tot = total_h; e_w = cur_w;
      e_prev = prev_h; e_h = cur_h; e_hf = h_first; e_g = g_cnt; e_rc = r_cnt;
    end else begin
      e_ovf  = 1'b0;
      e_px   = -POS_W'(half_width);
      e_py   = POS_W'(half_height);
      e_tot  = '0;
      e_w    = -POS_W'(gap_x);
      e_prev = '0; e_h = '0; e_hf = '0; e_g = '0;
      e_rc   = CNT_W'(1);
    end
  end

  // One glyph step
  logic signed [ACC_W-1:0] s_left, s_top, s_bw, s_bh, s_step, s_hw, s_px, s_py;
  logic signed [ACC_W-1:0] s_line, b_px, b_py, b_tot, b_w, gx, gy, s_wrap;
  logic                    brk, wrap, nl_any, full, take, raise;
  logic [CNT_W-1:0]        b_rc;
  logic [HGT_W-1:0]        b_h, n_h, n_prev;
  glyph_rec_t              g_wr;

  always_comb begin
    s_left = ACC_W'(bearing_left);
    s_top  = ACC_W'(bearing_top);
    s_bw   = ACC_W'(box_width);
    s_bh   = ACC_W'(box_height);
    s_step = ACC_W'(advance) + ACC_W'(gap_x);
    s_hw   = ACC_W'(half_width);
    s_px   = ACC_W'(e_px);
    s_py   = ACC_W'(e_py);
    s_line = ACC_W'(e_prev) + ACC_W'(gap_y);
    s_wrap = s_px + s_left + s_bw;
    brk    = is_newline && !single_line;
    wrap   = !brk && !single_line && (s_wrap >= s_hw);
    nl_any = brk || wrap;
    full   = (e_g >= CNT_W'(MAX_GLYPHS)) || (nl_any && (e_rc >= CNT_W'(MAX_ROWS)));
    take   = !e_ovf && !full;
    // break to a new line first where needed
    b_px   = nl_any ? -s_hw : s_px;
    b_py   = nl_any ? s_py - s_line : s_py;
    b_tot  = nl_any ? ACC_W'(e_tot) + s_line : ACC_W'(e_tot);
    b_w    = nl_any ? -ACC_W'(gap_x) : ACC_W'(e_w);
    b_h    = nl_any ? '0 : e_h;
    b_rc   = nl_any ? e_rc + CNT_W'(1) : e_rc;
    gx     = ((b_px + s_left) <<< 2) + (s_bw <<< 1);
    gy     = ((b_py + s_top) <<< 2) - (s_bh <<< 1);
    raise  = !brk && (HGT_W'(box_height) > b_h);
    n_h    = raise ? HGT_W'(box_height) : b_h;
    n_prev = raise ? HGT_W'(box_height) : e_prev;
    g_wr.brk = brk;
    g_wr.row = brk ? ROW_W'(e_rc - CNT_W'(1)) : ROW_W'(b_rc - CNT_W'(1));
    g_wr.x   = brk ? '0 : gx[POS_W-1:0];
    g_wr.y   = brk ? '0 : gy[POS_W-1:0];
  end

  // Commit a beat; close the run after the last result
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run   <= 1'b0;
      overflow <= 1'b0;
    end else if (cmd.load) begin
      in_run <= 1'b1;
      if (take) begin
        overflow <= 1'b0;
        pen_x    <= brk ? b_px[POS_W-1:0] : POS_W'(b_px + s_step);
        cur_w    <= brk ? b_w[POS_W-1:0] : POS_W'(b_w + s_step);
        pen_y    <= b_py[POS_W-1:0];
        total_h  <= b_tot[POS_W-1:0];
        cur_h    <= n_h;
        prev_h   <= n_prev;
        h_first  <= (b_rc == CNT_W'(1)) ? n_h : e_hf;
        g_cnt    <= e_g + CNT_W'(1);
        r_cnt    <= b_rc;
      end else begin
        overflow <= 1'b1;
        pen_x <= e_px; cur_w <= e_w; pen_y <= e_py; total_h <= e_tot;
        cur_h <= e_h; prev_h <= e_prev; h_first <= e_hf; g_cnt <= e_g; r_cnt <= e_rc;
      end
    end else if (cmd.end_run) begin
      in_run <= 1'b0;
    end
  end

  // Glyph store
  glyph_rec_t glyph_mem [MAX_GLYPHS];
  glyph_rec_t gq;
  logic [CNT_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (cmd.load && take) glyph_mem[e_g[GA_W-1:0]] <= g_wr;
    gq <= glyph_mem[idx[GA_W-1:0]];
  end

  // Line store: follows the current line, written from the registered line state
  row_rec_t row_mem [MAX_ROWS];
  row_rec_t rq, r_wr;
  logic [CNT_W-1:0] r_wa;
  logic [RA_W-1:0]  r_ra, first, last;
  logic             found;

  assign r_wr.w = e_w;
  assign r_wr.h = e_h;
  assign r_wa   = e_rc - CNT_W'(1);

  always_comb begin
    case (cmd.row_sel)
      RSEL_FIRST: r_ra = first;
      RSEL_LAST:  r_ra = last;
      default:    r_ra = gq.row[RA_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.row_track && (in_run || cmd.load)) row_mem[r_wa[RA_W-1:0]] <= r_wr;
    rq <= row_mem[r_ra];
  end

  // Step counter for glyph and line passes
  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (cmd.idx_clr) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + CNT_W'(1);
  end

  // Vertical offset, clipping and the search for the first and last kept lines
  logic signed [ACC_W-1:0] oy, s_hh, s_y, s_hl, oy_first, oy_final;
  logic [MAX_ROWS-1:0]     clipped;
  logic [HGT_W-1:0]        hf;

  always_comb begin
    s_hh     = ACC_W'(half_height);
    s_y      = ACC_W'(gq.y) + oy;
    s_hl     = ACC_W'(rq.h) <<< 1;
    oy_first = v_offset(align_v, s_hh, ACC_W'(total_h), ACC_W'(h_first), ACC_W'(cur_h));
    oy_final = found ? v_offset(align_v, s_hh, ACC_W'(total_h), ACC_W'(hf), ACC_W'(rq.h))
                     : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clipped <= '0;
      found   <= 1'b0;
    end else begin
      if (cmd.end_run) clipped <= '0;
      else if (cmd.clip_chk && !gq.brk &&
               ((s_y + s_hl > (s_hh <<< 2)) || (s_y - s_hl < -(s_hh <<< 2))))
        clipped[gq.row[RA_W-1:0]] <= 1'b1;
      if (cmd.flush) found <= 1'b0;
      else if (cmd.scan_step && !clipped[idx[RA_W-1:0]]) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) oy <= oy_first;
    else if (cmd.set_oy) oy <= oy_final;
    if (cmd.scan_step && !clipped[idx[RA_W-1:0]]) begin
      if (!found) first <= idx[RA_W-1:0];
      last <= idx[RA_W-1:0];
    end
    if (cmd.cap_hf) hf <= rq.h;
  end

  // Result register
  logic signed [ACC_W-1:0] ox;
  assign ox = h_offset(align_h, ACC_W'(half_width), ACC_W'(rq.w));

  always_ff @(posedge clk) begin
    if (cmd.emit_calc) begin
      dropped  <= overflow;
      last_out <= status.empty || status.idx_last_glyph;
      if (status.empty) begin
        pos_x <= '0; pos_y <= '0; row <= '0; visible <= 1'b0;
      end else begin
        row <= gq.row;
        if (gq.brk) begin
          pos_x <= '0; pos_y <= '0; visible <= 1'b0;
        end else begin
          pos_x   <= sat_pos(ACC_W'(gq.x) + ox);
          pos_y   <= sat_pos(ACC_W'(gq.y) + oy);
          visible <= !clipped[gq.row[RA_W-1:0]];
        end
      end
    end
  end

  assign status.empty          = (g_cnt == '0);
  assign status.idx_last_glyph = (idx == g_cnt - CNT_W'(1));
  assign status.idx_last_row   = (idx == r_cnt - CNT_W'(1));

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the glyph line wrap layout block: texts checked against a layout predictor.
`default_nettype none
module testbench
  import glw_pkg::*;
();

  typedef struct {
    logic signed [7:0] left;
    logic signed [8:0] top;
    logic [7:0]        adv;
    logic [7:0]        bw;
    logic [7:0]        bh;
    logic              nl;
    logic              fin;
  } glyph_t;

  typedef struct {
    logic signed [18:0] pos_x;
    logic signed [18:0] pos_y;
    logic [5:0]         row;
    logic               visible;
    logic               dropped;
    logic               last_out;
  } placed_t;

  logic clk;
  logic rst;
  logic write_en;
  logic [CFG_IDX_W-1:0] write_index;
  logic [CFG_DATA_W-1:0] write_data;

  glw_glyph_if  gi ();
  glw_result_if ri ();

  glyph_line_wrap_layout dut (
    .clk(clk), .rst(rst), .glyphs(gi), .results(ri),
    .write_en(write_en), .write_index(write_index), .write_data(write_data)
  );

  // Layout settings as last written
  int half_w, half_h, gap_x, gap_y, one_line, align_h, align_v;
  // Text in progress
  int gl_x[MAX_GLYPHS_DEF], gl_y[MAX_GLYPHS_DEF], gl_row[MAX_GLYPHS_DEF];
  bit gl_brk[MAX_GLYPHS_DEF];
  int ln_w[MAX_ROWS_DEF], ln_h[MAX_ROWS_DEF];
  bit ln_clip[MAX_ROWS_DEF];
  int pen_x, pen_y, text_h, last_rise, n_glyphs, n_lines;
  bit overflowed, text_open;

  placed_t expected_q[$];
  int mismatches, glyphs_sent, placed_seen, texts_sent;
  int hold_rx;
  bit tx_idle, rx_idle;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // ---------------- layout predictor ----------------
  function automatic void open_line(int r);
    ln_w[r] = -gap_x;
    ln_h[r] = 0;
    ln_clip[r] = 1'b0;
  endfunction

  function automatic void start_text();
    for (int r = 0; r < MAX_ROWS_DEF; r++) ln_clip[r] = 1'b0;
    pen_x = -half_w;
    pen_y = half_h;
    text_h = 0;
    last_rise = 0;
    n_glyphs = 0;
    n_lines = 1;
    overflowed = 1'b0;
    open_line(0);
    text_open = 1'b1;
  endfunction

  function automatic void break_line();
    pen_x = -half_w;
    pen_y -= last_rise + gap_y;
    text_h += last_rise + gap_y;
    open_line(n_lines);
    n_lines++;
  endfunction

  function automatic longint vert_offset(int h_first, int h_last);
    longint span;
    span = 2 * longint'(half_h) - text_h;
    case (align_v)
      ALIGN_FIRST:  return -4 * longint'(h_first);
      ALIGN_MIDDLE: return -2 * span - 2 * longint'(h_first);
      ALIGN_LAST:   return -4 * span + 2 * longint'(h_last);
      default:      return 0;
    endcase
  endfunction

  function automatic longint horiz_offset(int w);
    longint span;
    span = 2 * longint'(half_w) - w;
    case (align_h)
      ALIGN_MIDDLE: return 2 * span;
      ALIGN_LAST:   return 4 * span;
      default:      return 0;
    endcase
  endfunction

  function automatic logic signed [18:0] clamp19(longint v);
    if (v > 262143) v = 262143;
    if (v < -262144) v = -262144;
    return v[18:0];
  endfunction

  function automatic void lay_out_glyph(glyph_t gv);
    int left, top, adv, bw, bh, g, r, first, last;
    bit brk, wrap;
    longint oy, y, hl;
    placed_t p;
    left = int'(gv.left);
    top = int'(gv.top);
    adv = int'(gv.adv);
    bw = int'(gv.bw);
    bh = int'(gv.bh);
    first = -1;
    last = -1;
    if (!text_open) start_text();
    if (!overflowed) begin
      brk = gv.nl && one_line == 0;
      wrap = !brk && one_line == 0 && pen_x + left + bw >= half_w;
      if (n_glyphs >= MAX_GLYPHS_DEF || ((brk || wrap) && n_lines >= MAX_ROWS_DEF)) begin
        overflowed = 1'b1;
      end else begin
        g = n_glyphs;
        n_glyphs++;
        if (brk) begin
          gl_brk[g] = 1'b1;
          gl_row[g] = n_lines - 1;
          gl_x[g] = 0;
          gl_y[g] = 0;
          break_line();
        end else begin
          if (wrap) break_line();
          r = n_lines - 1;
          gl_brk[g] = 1'b0;
          gl_row[g] = r;
          gl_x[g] = 4 * (pen_x + left) + 2 * bw;
          gl_y[g] = 4 * (pen_y + top) - 2 * bh;
          pen_x += adv + gap_x;
          ln_w[r] += adv + gap_x;
          if (bh > ln_h[r]) begin
            ln_h[r] = bh;
            last_rise = bh;
          end
        end
      end
    end
    if (!gv.fin) return;
    text_open = 1'b0;
    texts_sent++;
    // A text with nothing stored still closes with one beat
    if (n_glyphs == 0) begin
      p.pos_x = '0;
      p.pos_y = '0;
      p.row = '0;
      p.visible = 1'b0;
      p.dropped = overflowed;
      p.last_out = 1'b1;
      expected_q = {expected_q, p};
      return;
    end
    // Clip lines against the box using the first vertical offset
    oy = vert_offset(ln_h[0], ln_h[n_lines - 1]);
    for (g = 0; g < n_glyphs; g++) begin
      if (!gl_brk[g]) begin
        r = gl_row[g];
        y = longint'(gl_y[g]) + oy;
        hl = 2 * longint'(ln_h[r]);
        if (y + hl > 4 * longint'(half_h) || y - hl < -4 * longint'(half_h))
          ln_clip[r] = 1'b1;
      end
    end
    for (r = 0; r < n_lines; r++) begin
      if (!ln_clip[r]) begin
        if (first < 0) first = r;
        last = r;
      end
    end
    oy = (first < 0) ? 0 : vert_offset(ln_h[first], ln_h[last]);
    // Queue one placed glyph per stored glyph
    for (g = 0; g < n_glyphs; g++) begin
      r = gl_row[g];
      if (gl_brk[g]) begin
        p.pos_x = '0;
        p.pos_y = '0;
        p.visible = 1'b0;
      end else begin
        p.pos_x = clamp19(longint'(gl_x[g]) + horiz_offset(ln_w[r]));
        p.pos_y = clamp19(longint'(gl_y[g]) + oy);
        p.visible = !ln_clip[r];
      end
      p.row = r[5:0];
      p.dropped = overflowed;
      p.last_out = (g + 1 == n_glyphs);
      expected_q = {expected_q, p};
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_glyph(glyph_t gv);
    int idle;
    idle = tx_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (idle > 0) begin
      gi.valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    gi.bearing_left = gv.left;
    gi.bearing_top = gv.top;
    gi.advance = gv.adv;
    gi.box_width = gv.bw;
    gi.box_height = gv.bh;
    gi.is_newline = gv.nl;
    gi.final_glyph = gv.fin;
    gi.valid = 1'b1;
    do @(posedge clk); while (!gi.ready);
    lay_out_glyph(gv);
    glyphs_sent++;
    // Drop valid after the closing beat; the next text waits for the results
    if (gv.fin) begin
      @(negedge clk);
      gi.valid = 1'b0;
    end
  endtask

  function automatic glyph_t make_glyph(bit full_range, bit nl, bit fin);
    glyph_t gv;
    if (full_range) begin
      gv.left = 8'($urandom);
      gv.top = 9'($urandom);
      gv.adv = 8'($urandom);
      gv.bw = 8'($urandom);
      gv.bh = 8'($urandom);
    end else begin
      gv.left = 8'(int'($urandom_range(0, 6)) - 3);
      gv.top = 9'($urandom_range(0, 24));
      gv.adv = 8'($urandom_range(4, 24));
      gv.bw = 8'($urandom_range(0, 20));
      gv.bh = 8'($urandom_range(0, 24));
    end
    gv.nl = nl;
    gv.fin = fin;
    return gv;
  endfunction

  task automatic wait_idle();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    @(negedge clk);
    write_en = 1'b1;
    write_index = idx;
    write_data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    write_en = 1'b0;
    case (idx)
      REG_HALF_WIDTH:  half_w = value & 12'hFFF;
      REG_HALF_HEIGHT: half_h = value & 12'hFFF;
      REG_GAP_X:       gap_x = int'($signed(value[7:0]));
      REG_GAP_Y:       gap_y = int'($signed(value[7:0]));
      REG_SINGLE_LINE: one_line = value & 1;
      REG_ALIGN_H:     align_h = value & 3;
      REG_ALIGN_V:     align_v = value & 3;
      default: ;
    endcase
  endtask

  task automatic set_layout(int hw, int hh, int gx, int gy, int sl, int ah, int av);
    wait_idle();
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_HALF_HEIGHT, hh);
    write_reg(REG_GAP_X, gx);
    write_reg(REG_GAP_Y, gy);
    write_reg(REG_SINGLE_LINE, sl);
    write_reg(REG_ALIGN_H, ah);
    write_reg(REG_ALIGN_V, av);
  endtask

  task automatic send_text(int len, bit full_range, int nl_odds);
    for (int i = 0; i < len; i++)
      send_glyph(make_glyph(full_range, $urandom_range(0, nl_odds - 1) == 0, i == len - 1));
  endtask

  // ---------------- receiver ----------------
  initial begin
    ri.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx > 0) begin
        ri.ready = 1'b0;
        repeat (hold_rx) @(negedge clk);
        hold_rx = 0;
      end
      if (rx_idle) begin
        int stall;
        stall = $urandom_range(0, 7);
        if (stall > 0) begin
          ri.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      ri.ready = 1'b1;
      do @(posedge clk); while (!(ri.valid && !rst));
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && ri.valid && ri.ready) begin
      placed_t want;
      placed_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: x=%0d y=%0d row=%0d",
                                       ri.pos_x, ri.pos_y, ri.row);
      end else begin
        want = expected_q.pop_front();
        if (ri.pos_x !== want.pos_x || ri.pos_y !== want.pos_y || ri.row !== want.row ||
            ri.visible !== want.visible || ri.dropped !== want.dropped ||
            ri.last_out !== want.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d row=%0d vis=%b drop=%b last=%b,",
                     want.pos_x, want.pos_y, want.row, want.visible, want.dropped,
                     want.last_out,
                     " got x=%0d y=%0d row=%0d vis=%b drop=%b last=%b",
                     ri.pos_x, ri.pos_y, ri.row, ri.visible, ri.dropped, ri.last_out);
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_field_extremes();
    glyph_t gv;
    // Default settings: extremes of every field, a newline and a forced wrap
    gv = '{8'sh80, 9'sh100, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0};     send_glyph(gv);
    gv = '{8'sh7f, 9'sh0ff, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0}; send_glyph(gv);
    gv = '{8'sh00, 9'sh010, 8'd10, 8'd8, 8'd12, 1'b1, 1'b0};   send_glyph(gv);
    gv = '{8'sh7f, 9'sh0ff, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0}; send_glyph(gv);
    gv = '{8'sh7f, 9'sh000, 8'd200, 8'd255, 8'd4, 1'b0, 1'b1}; send_glyph(gv);
    // Single glyph text, and a newline closing the text
    send_glyph('{8'sh02, 9'sh008, 8'd9, 8'd7, 8'd10, 1'b0, 1'b1});
    send_glyph('{8'sh00, 9'sh000, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1});
  endtask

  task automatic test_alignments();
    // Every alignment pair, including the unused code, on a small box
    for (int ah = 0; ah < 4; ah++)
      for (int av = 0; av < 4; av++) begin
        set_layout(60, 40, 1, 2, 0, ah, av);
        send_text(1, 0, 1000);
      end
    // Box and gap extremes, single-line mode with newlines laid out as glyphs
    set_layout(0, 0, -128, -128, 0, ALIGN_LAST, ALIGN_MIDDLE);
    send_text(2, 1, 2);
    set_layout(4095, 4095, 127, 127, 1, ALIGN_MIDDLE, ALIGN_LAST);
    send_text(3, 1, 2);
    set_layout(4095, 4095, 127, 127, 0, ALIGN_FIRST, ALIGN_FIRST);
    send_text(3, 1, 2);
  endtask

  task automatic test_glyph_capacity();
    // Long stall on the receiver while a full text and the next one queue up
    set_layout(4095, 200, 0, 0, 1, ALIGN_FIRST, ALIGN_FIRST);
    hold_rx = 400;
    send_text(MAX_GLYPHS_DEF + 1, 0, 1000);
    send_text(1, 0, 1000);
  endtask

  task automatic test_line_capacity();
    set_layout(100, 4095, 0, 0, 0, ALIGN_FIRST, ALIGN_MIDDLE);
    for (int i = 0; i < MAX_ROWS_DEF; i++)
      send_glyph('{8'sh00, 9'sh004, 8'd3, 8'd2, 8'd2, 1'b1, i == MAX_ROWS_DEF - 1});
  endtask

  task automatic test_random_texts();
    int sent;
    sent = 0;
    while (sent < 20) begin
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      set_layout($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(20, 200),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(10, 150),
                 $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 4) == 0, $urandom_range(0, 3), $urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_GAP_X, $urandom_range(0, 4));
        write_reg(REG_GAP_Y, $urandom_range(0, 4));
      end
      for (int i = 0; i < len; i++)
        send_glyph(make_glyph($urandom_range(0, 4) == 0, $urandom_range(0, 7) == 0,
                              i == len - 1));
      sent += len;
    end
  endtask

  initial begin
    half_w = 256; half_h = 64; gap_x = 0; gap_y = 0;
    one_line = 0; align_h = ALIGN_FIRST; align_v = ALIGN_FIRST;
    text_open = 1'b0;
    mismatches = 0; glyphs_sent = 0; placed_seen = 0; texts_sent = 0;
    hold_rx = 0; tx_idle = 1'b1; rx_idle = 1'b1;
    rst = 1'b1;
    write_en = 1'b0; write_index = '0; write_data = '0;
    gi.valid = 1'b0; gi.bearing_left = '0; gi.bearing_top = '0; gi.advance = '0;
    gi.box_width = '0; gi.box_height = '0; gi.is_newline = 1'b0; gi.final_glyph = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_alignments();
    test_glyph_capacity();
    test_line_capacity();
    test_random_texts();

    wait_idle();
    repeat (20) @(negedge clk);
    $display("covered %0d texts, %0d glyph beats, %0d placed glyph beats", texts_sent,
             glyphs_sent, placed_seen);
    $display("alignments, box extremes, wraps, newlines, capacity overflow; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #4000000;
    $display("timeout");
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
